@@ rtl/tgc_pkg.sv @@
`default_nettype none
package tgc_pkg;
    localparam int SCREEN_WIDTH  = 400;
    localparam int SCREEN_HEIGHT = 300;
    localparam int STATUS_BAR_H  = 24;
    localparam int BACK_EDGE_Y   = 270;
    localparam int BACK_MINX     = 100;
    localparam int BACK_MAXX     = 300;
    localparam int BACK_DY       = 50;

    localparam logic [2:0] REG_PANEL_W = 3'd0;
    localparam logic [2:0] REG_PANEL_H = 3'd1;
    localparam logic [2:0] REG_ROT     = 3'd2;
    localparam logic [2:0] REG_SWIPE   = 3'd3;
    localparam logic [2:0] REG_STILL   = 3'd4;
    localparam logic [2:0] REG_LONG    = 3'd5;
    localparam logic [2:0] REG_HOLD    = 3'd6;

    typedef enum logic [3:0] {
        ACT_NONE = 4'd0, ACT_CONFIRM = 4'd1, ACT_LONG = 4'd2, ACT_HOME = 4'd3,
        ACT_BACK = 4'd4, ACT_LEFT = 4'd5, ACT_RIGHT = 4'd6, ACT_UP = 4'd7,
        ACT_DOWN = 4'd8
    } action_t;

    typedef enum logic [1:0] {GS_IDLE = 2'd0, GS_PRESS = 2'd1, GS_WAIT = 2'd2} gstate_t;

    typedef enum logic [1:0] {MS_IDLE = 2'd0, MS_DIVX = 2'd1, MS_DIVY = 2'd2,
                              MS_DONE = 2'd3} mstate_t;

    // one queued sample after scaling and rotation
    typedef struct packed {
        logic        pressed;
        logic [15:0] raw_x;
        logic [15:0] raw_y;
        logic [31:0] time_ms;
        logic [8:0]  scr_x;
        logic [8:0]  scr_y;
    } sample_t;

    typedef struct packed {
        logic [15:0] panel_w;
        logic [15:0] panel_h;
        logic [1:0]  rot;
        logic [9:0]  swipe_min;
        logic [9:0]  still_max;
        logic [15:0] long_ms;
        logic [15:0] hold_ms;
    } cfg_t;
endpackage
`default_nettype wire

@@ rtl/touch_gesture_classifier.sv @@
`default_nettype none
// Touch gesture classifier.
// Input stream s_axis: one touch sample per word. Output stream m_axis: exactly
// one result word per sample, in order.
// Configuration: cfg_we/cfg_index/cfg_data write one register per cycle; the
// user must write only while the block is idle, as the block does not enforce it.
// A front mapper scales the raw point by the panel resolution, if nonzero, with a
// one-bit-per-cycle divider (two divisions, one per axis), clamps and
// rotates it, then pushes it into a two-entry queue. The back classifier pops
// one sample per cycle while the queue holds one and the output register is free,
// runs the gesture machine and loads the output register. The mapper takes a
// new sample only after it has pushed the last one into the queue.
// Reset clears the gesture state, queue and output valid, and loads the
// register defaults. When m_axis_tready is low the result is held; the queue
// fills with two samples and the mapper holds a third before s_axis_tready
// stays low.
module touch_gesture_classifier (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // touch_pressed[0], raw_x[16:1], raw_y[32:17], time_ms[64:33], zero pad
    input  wire logic [71:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // action[3:0], tap_valid[4], tap_x[13:5], tap_y[22:14], touch_down[23],
    // live_x[32:24], live_y[41:33], zero pad
    output logic [47:0]      m_axis_tdata
);
    import tgc_pkg::*;
    cfg_t    cfg_reg;
    logic    q_push, q_full, q_pop, q_empty;
    sample_t q_in, q_out;
    logic [41:0] word;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{panel_w: 16'd0, panel_h: 16'd0, rot: 2'd0, swipe_min: 10'd40,
                         still_max: 10'd20, long_ms: 16'd800, hold_ms: 16'd3000};
        end else if (cfg_we) begin
            case (cfg_index)
                REG_PANEL_W: cfg_reg.panel_w   <= cfg_data;
                REG_PANEL_H: cfg_reg.panel_h   <= cfg_data;
                REG_ROT:     cfg_reg.rot       <= cfg_data[1:0];
                REG_SWIPE:   cfg_reg.swipe_min <= cfg_data[9:0];
                REG_STILL:   cfg_reg.still_max <= cfg_data[9:0];
                REG_LONG:    cfg_reg.long_ms   <= cfg_data;
                REG_HOLD:    cfg_reg.hold_ms   <= cfg_data;
                default: ;
            endcase
        end
    end

    tgc_mapper u_map (
        .aclk(aclk), .aresetn(aresetn), .cfg(cfg_reg), .in_valid(s_axis_tvalid),
        .in_ready(s_axis_tready), .in_word(s_axis_tdata[64:0]), .q_push(q_push),
        .q_data(q_in), .q_full(q_full)
    );

    tgc_fifo u_fifo (
        .aclk(aclk), .aresetn(aresetn), .push(q_push), .push_data(q_in), .full(q_full),
        .pop(q_pop), .empty(q_empty), .pop_data(q_out)
    );

    tgc_classifier u_cls (
        .aclk(aclk), .aresetn(aresetn), .cfg(cfg_reg), .q_empty(q_empty),
        .q_data(q_out), .q_pop(q_pop), .out_valid(m_axis_tvalid),
        .out_ready(m_axis_tready), .out_word(word)
    );

    assign m_axis_tdata = {6'd0, word};
endmodule
`default_nettype wire

@@ rtl/tgc_divider.sv @@
`default_nettype none
// unsigned restoring divider, one quotient bit a cycle
module tgc_divider (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [24:0] dividend,
    input  wire logic [15:0] divisor,
    output logic             done,
    output logic [24:0]      quotient
);
    import tgc_pkg::*;
    logic [24:0] quo_reg, quo_next;
    logic [15:0] rem_reg, rem_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [16:0] trial;
    logic [16:0] diff;

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {rem_reg, quo_reg[24]};
        diff      = trial - {1'b0, divisor};
        done      = 1'b0;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = 5'd0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // remainder stays below the divisor, so 16 bits hold it
            if (trial >= {1'b0, divisor}) begin
                rem_next = diff[15:0];
                quo_next = {quo_reg[23:0], 1'b1};
            end else begin
                rem_next = trial[15:0];
                quo_next = {quo_reg[23:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd24) begin
                busy_next = 1'b0;
                done      = 1'b1;
            end
        end
    end

    assign quotient = quo_next;

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
        if (!aresetn) busy_reg <= 1'b0;
        else          busy_reg <= busy_next;
    end
endmodule
`default_nettype wire

@@ rtl/tgc_mapper.sv @@
`default_nettype none
// front part: scale, clamp and rotate one sample, push it to the queue
module tgc_mapper (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire tgc_pkg::cfg_t    cfg,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [64:0]      in_word,
    output logic                  q_push,
    output tgc_pkg::sample_t      q_data,
    input  wire logic             q_full
);
    import tgc_pkg::*;
    mstate_t state_reg, state_next;
    logic        pressed_reg;
    logic [15:0] rx_reg, ry_reg;
    logic [31:0] t_reg;
    logic [15:0] sx_reg, sy_reg;  // signed scaled values
    logic        div_start, div_done;
    logic [24:0] dividend, quotient;
    logic [15:0] divisor;
    logic        scale_en, neg;
    logic [24:0] prod_mag;
    logic [15:0] src, mag16, qs;
    logic [8:0]  cx, cy;
    logic        first_reg;
    logic        busy_any;
    logic        run_reg;

    assign scale_en = (cfg.panel_w != 16'd0) && (cfg.panel_h != 16'd0);
    assign src      = (state_reg == MS_DIVX) ? rx_reg : ry_reg;
    assign neg      = src[15];
    assign mag16    = neg ? (16'd0 - src) : src;
    assign divisor  = (state_reg == MS_DIVX) ? cfg.panel_w : cfg.panel_h;

    always_ff @(posedge aclk) begin
        prod_mag <= (state_reg == MS_DIVX || (state_reg == MS_IDLE))
                    ? 25'(mag16) * 25'(SCREEN_WIDTH) : 25'(mag16) * 25'(SCREEN_HEIGHT);
    end
    assign dividend  = prod_mag;
    // quotient saturated to 32767, so the 25-bit result fits the 16-bit signed value
    logic [24:0] qclip;
    assign qclip = quotient;
    assign qs = (qclip > 25'd32767) ? 16'd32767 : qclip[15:0];

    always_comb begin
        state_next = state_reg;
        in_ready   = 1'b0;
        div_start  = 1'b0;
        q_push     = 1'b0;
        case (state_reg)
            MS_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) state_next = scale_en ? MS_DIVX : MS_DONE;
            end
            MS_DIVX: begin
                div_start = first_reg;
                if (div_done) state_next = MS_DIVY;
            end
            MS_DIVY: begin
                div_start = first_reg;
                if (div_done) state_next = MS_DONE;
            end
            MS_DONE: begin
                if (!q_full) begin
                    q_push     = 1'b1;
                    state_next = MS_IDLE;
                end
            end
            default: state_next = MS_IDLE;
        endcase
    end

    tgc_divider u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .dividend(dividend),
        .divisor(divisor), .done(div_done), .quotient(quotient)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= MS_IDLE;
            first_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            // let the product register load before starting
            if (state_next != state_reg) first_reg <= 1'b0;
            else first_reg <= (state_reg == MS_DIVX || state_reg == MS_DIVY) &&
                              !first_reg && !div_start && !busy_any;
        end
        if (in_ready && in_valid) begin
            pressed_reg <= in_word[0];
            rx_reg      <= in_word[16:1];
            ry_reg      <= in_word[32:17];
            t_reg       <= in_word[64:33];
            sx_reg      <= in_word[16:1];
            sy_reg      <= in_word[32:17];
        end
        if (div_done && state_reg == MS_DIVX) sx_reg <= neg ? (16'd0 - qs) : qs;
        if (div_done && state_reg == MS_DIVY) sy_reg <= neg ? (16'd0 - qs) : qs;
    end

    // divider busy tracking so start fires exactly once per phase
    always_ff @(posedge aclk) begin
        if (!aresetn) run_reg <= 1'b0;
        else if (div_start) run_reg <= 1'b1;
        else if (div_done || state_reg == MS_IDLE) run_reg <= 1'b0;
    end
    assign busy_any = run_reg;

    always_comb begin
        if (sx_reg[15])                                   cx = 9'd0;
        else if (sx_reg > 16'(SCREEN_WIDTH - 1))          cx = 9'(SCREEN_WIDTH - 1);
        else                                              cx = sx_reg[8:0];
        if (sy_reg[15])                                   cy = 9'd0;
        else if (sy_reg > 16'(SCREEN_HEIGHT - 1))         cy = 9'(SCREEN_HEIGHT - 1);
        else                                              cy = sy_reg[8:0];
        q_data.pressed = pressed_reg;
        q_data.raw_x   = rx_reg;
        q_data.raw_y   = ry_reg;
        q_data.time_ms = t_reg;
        case (cfg.rot)
            2'd1: begin
                q_data.scr_x = 9'(SCREEN_WIDTH - 1) - cx;
                q_data.scr_y = 9'(SCREEN_HEIGHT - 1) - cy;
            end
            2'd2: begin
                q_data.scr_x = cy;
                q_data.scr_y = 9'(SCREEN_WIDTH - 1) - cx;
            end
            2'd3: begin
                q_data.scr_x = 9'(SCREEN_HEIGHT - 1) - cy;
                q_data.scr_y = cx;
            end
            default: begin
                q_data.scr_x = cx;
                q_data.scr_y = cy;
            end
        endcase
    end
endmodule
`default_nettype wire

@@ rtl/tgc_fifo.sv @@
`default_nettype none
// two-entry queue between mapper and classifier
module tgc_fifo (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire tgc_pkg::sample_t  push_data,
    output logic                   full,
    input  wire logic              pop,
    output logic                   empty,
    output tgc_pkg::sample_t       pop_data
);
    import tgc_pkg::*;
    sample_t    mem [2];
    logic       wr_reg, rd_reg;
    logic [1:0] cnt_reg;

    assign full     = (cnt_reg == 2'd2);
    assign empty    = (cnt_reg == 2'd0);
    assign pop_data = mem[rd_reg];

    always_ff @(posedge aclk) begin
        if (push && !full) mem[wr_reg] <= push_data;
        if (!aresetn) begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push && !full) wr_reg <= ~wr_reg;
            if (pop && !empty) rd_reg <= ~rd_reg;
            cnt_reg <= cnt_reg + 2'(push && !full) - 2'(pop && !empty);
        end
    end
endmodule
`default_nettype wire

@@ rtl/tgc_classifier.sv @@
`default_nettype none
// back part: gesture state machine and output register
module tgc_classifier (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire tgc_pkg::cfg_t     cfg,
    input  wire logic              q_empty,
    input  wire tgc_pkg::sample_t  q_data,
    output logic                   q_pop,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [41:0]            out_word
);
    import tgc_pkg::*;
    gstate_t     gs_reg, gs_next;
    logic signed [15:0] ox_reg, oy_reg, lx_reg, ly_reg;
    logic [8:0]  osx_reg, osy_reg, px_reg, py_reg;
    logic [31:0] pt_reg;
    logic        home_reg;
    logic        valid_reg;
    logic [41:0] word_reg;

    logic        take;
    logic signed [16:0] dx, dy, hdx, hdy;
    logic [16:0] adx, ady, hadx, hady;
    logic [31:0] dt;
    action_t     act;
    logic        tap;
    logic [8:0]  nx, ny;

    assign take  = !q_empty && (!valid_reg || out_ready);
    assign q_pop = take;
    assign dt    = q_data.time_ms - pt_reg;
    assign dx    = 17'(lx_reg) - 17'(ox_reg);
    assign dy    = 17'(ly_reg) - 17'(oy_reg);
    assign adx   = dx[16] ? 17'(-dx) : 17'(dx);
    assign ady   = dy[16] ? 17'(-dy) : 17'(dy);
    assign hdx   = 17'($signed(q_data.raw_x)) - 17'(ox_reg);
    assign hdy   = 17'($signed(q_data.raw_y)) - 17'(oy_reg);
    assign hadx  = hdx[16] ? 17'(-hdx) : 17'(hdx);
    assign hady  = hdy[16] ? 17'(-hdy) : 17'(hdy);

    always_comb begin
        gs_next = gs_reg;
        act     = ACT_NONE;
        tap     = 1'b0;
        case (gs_reg)
            GS_PRESS: begin
                if (q_data.pressed) begin
                    if (!home_reg && osy_reg < 9'(STATUS_BAR_H) && !dt[31] &&
                        dt >= 32'(cfg.hold_ms) && hadx < 17'(cfg.still_max) &&
                        hady < 17'(cfg.still_max)) begin
                        act     = ACT_HOME;
                        gs_next = GS_WAIT;
                    end
                end else begin
                    if (dt >= 32'(cfg.long_ms) && osy_reg >= 9'(STATUS_BAR_H) &&
                        adx < 17'(cfg.still_max) && ady < 17'(cfg.still_max)) begin
                        act = ACT_LONG;
                        tap = 1'b1;
                    end else if (adx < 17'(cfg.swipe_min) && ady < 17'(cfg.swipe_min)) begin
                        act = ACT_CONFIRM;
                        tap = 1'b1;
                    end else if (oy_reg >= 16'sd270 && ox_reg >= 16'sd100 &&
                                 ox_reg <= 16'sd300 && dy <= -17'sd50) begin
                        act = ACT_BACK;
                    end else if (adx >= ady) begin
                        act = (dx > 17'sd0) ? ACT_RIGHT : ACT_LEFT;
                    end else begin
                        act = (dy > 17'sd0) ? ACT_DOWN : ACT_UP;
                    end
                    gs_next = GS_IDLE;
                end
            end
            GS_WAIT: begin
                if (!q_data.pressed) gs_next = GS_IDLE;
            end
            default: begin
                gs_next = q_data.pressed ? GS_PRESS : GS_IDLE;
            end
        endcase
        nx = q_data.pressed ? q_data.scr_x : px_reg;
        ny = q_data.pressed ? q_data.scr_y : py_reg;
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gs_reg    <= GS_IDLE;
            valid_reg <= 1'b0;
            ox_reg <= '0; oy_reg <= '0; lx_reg <= '0; ly_reg <= '0;
            osx_reg <= '0; osy_reg <= '0; pt_reg <= '0; home_reg <= 1'b0;
            px_reg <= '0; py_reg <= '0;
        end else begin
            if (valid_reg && out_ready) valid_reg <= 1'b0;
            if (take) begin
                gs_reg    <= gs_next;
                valid_reg <= 1'b1;
                px_reg    <= nx;
                py_reg    <= ny;
                word_reg  <= {ny, nx, q_data.pressed,
                              tap ? osy_reg : 9'd0, tap ? osx_reg : 9'd0,
                              tap, act};
                if (gs_reg == GS_PRESS && q_data.pressed) begin
                    lx_reg <= q_data.raw_x;
                    ly_reg <= q_data.raw_y;
                    if (act == ACT_HOME) home_reg <= 1'b1;
                end
                if (gs_reg != GS_PRESS && gs_reg != GS_WAIT && q_data.pressed) begin
                    ox_reg   <= q_data.raw_x;
                    oy_reg   <= q_data.raw_y;
                    lx_reg   <= q_data.raw_x;
                    ly_reg   <= q_data.raw_y;
                    osx_reg  <= q_data.scr_x;
                    osy_reg  <= q_data.scr_y;
                    pt_reg   <= q_data.time_ms;
                    home_reg <= 1'b0;
                end
            end
        end
    end
endmodule
`default_nettype wire

@@ rtl/tgc_checker.sv @@
`default_nettype none
module tgc_assertions (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [47:0] m_axis_tdata
);
    // output held while stalled
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed under stall");
    // tap only on confirm or long press
    a_tap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[4] |->
        (m_axis_tdata[3:0] == 4'd1 || m_axis_tdata[3:0] == 4'd2))
        else $error("tap flag on wrong action");
    // action code in range
    a_act: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[3:0] <= 4'd8)
        else $error("bad action code");
    // home never carries a release
    a_home: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[3:0] == 4'd3 |-> m_axis_tdata[23])
        else $error("home without touch");
    a_rst: assert property (@(posedge aclk) !aresetn |=> !m_axis_tvalid)
        else $error("valid after reset");
endmodule

bind touch_gesture_classifier tgc_assertions u_chk (
    .aclk(aclk), .aresetn(aresetn), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire

@@ tb/sv/tgc_checker.sv @@
module tgc_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [71:0] s_axis_tdata,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [47:0] m_axis_tdata,
    output int               mismatch_count,
    output int               pending_count
);
    import tgc_pkg::*;

    // last member sits in the lowest bits, matching the result word
    typedef struct packed {
        logic [8:0] live_y;
        logic [8:0] live_x;
        logic       touch_down;
        logic [8:0] tap_y;
        logic [8:0] tap_x;
        logic       tap_valid;
        logic [3:0] action;
    } gesture_t;

    logic [15:0] pw, ph;
    logic [1:0]  rot;
    logic [9:0]  swipe_min, still_max;
    logic [15:0] long_ms, hold_ms;

    gstate_t     gs;
    int          org_rx, org_ry, last_rx, last_ry, org_sx, org_sy, ptr_x, ptr_y;
    logic [31:0] press_t;
    logic        home_done;

    gesture_t    expected_q[$];

    function automatic int clip(int v, int hi);
        if (v < 0) return 0;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int mag(int v);
        return v < 0 ? -v : v;
    endfunction

    function automatic void to_screen(input int rx, input int ry,
                                      output int sx, output int sy);
        int x, y, ox, oy;
        x = rx;
        y = ry;
        if (pw != 0 && ph != 0) begin
            x = (rx * SCREEN_WIDTH) / int'(pw);
            y = (ry * SCREEN_HEIGHT) / int'(ph);
        end
        ox = clip(x, SCREEN_WIDTH - 1);
        oy = clip(y, SCREEN_HEIGHT - 1);
        case (rot)
            2'd1: begin sx = SCREEN_WIDTH - 1 - ox; sy = SCREEN_HEIGHT - 1 - oy; end
            2'd2: begin sx = oy; sy = SCREEN_WIDTH - 1 - ox; end
            2'd3: begin sx = SCREEN_HEIGHT - 1 - oy; sy = ox; end
            default: begin sx = ox; sy = oy; end
        endcase
    endfunction

    function automatic gesture_t classify_sample(input logic [71:0] w);
        gesture_t    r;
        logic        down;
        int          rx, ry, dx, dy, adx, ady;
        logic [31:0] t, dt;
        down = w[0];
        rx = int'($signed(w[16:1]));
        ry = int'($signed(w[32:17]));
        t = w[64:33];
        r = '0;
        r.action = ACT_NONE;
        if (down) to_screen(rx, ry, ptr_x, ptr_y);
        dt = t - press_t;
        case (gs)
            GS_PRESS: begin
                if (down) begin
                    last_rx = rx;
                    last_ry = ry;
                    if (!home_done && org_sy < STATUS_BAR_H && !dt[31] && dt >= hold_ms &&
                        mag(last_rx - org_rx) < int'(still_max) &&
                        mag(last_ry - org_ry) < int'(still_max)) begin
                        home_done = 1'b1;
                        gs = GS_WAIT;
                        r.action = ACT_HOME;
                    end
                end else begin
                    dx = last_rx - org_rx;
                    dy = last_ry - org_ry;
                    adx = mag(dx);
                    ady = mag(dy);
                    if (dt >= long_ms && org_sy >= STATUS_BAR_H &&
                        adx < int'(still_max) && ady < int'(still_max)) begin
                        r.action = ACT_LONG;
                        r.tap_valid = 1'b1;
                    end else if (adx < int'(swipe_min) && ady < int'(swipe_min)) begin
                        r.action = ACT_CONFIRM;
                        r.tap_valid = 1'b1;
                    end else if (org_ry >= BACK_EDGE_Y && org_rx >= BACK_MINX &&
                                 org_rx <= BACK_MAXX && dy <= -BACK_DY) begin
                        r.action = ACT_BACK;
                    end else if (adx >= ady) begin
                        r.action = dx > 0 ? ACT_RIGHT : ACT_LEFT;
                    end else begin
                        r.action = dy > 0 ? ACT_DOWN : ACT_UP;
                    end
                    gs = GS_IDLE;
                end
            end
            GS_WAIT: if (!down) gs = GS_IDLE;
            default: begin
                gs = GS_IDLE;
                if (down) begin
                    gs = GS_PRESS;
                    org_rx = rx;
                    last_rx = rx;
                    org_ry = ry;
                    last_ry = ry;
                    to_screen(rx, ry, org_sx, org_sy);
                    press_t = t;
                    home_done = 1'b0;
                end
            end
        endcase
        if (r.tap_valid) begin
            r.tap_x = org_sx[8:0];
            r.tap_y = org_sy[8:0];
        end
        r.touch_down = down;
        r.live_x = ptr_x[8:0];
        r.live_y = ptr_y[8:0];
        return r;
    endfunction

    always @(posedge aclk) begin
        gesture_t want, got;
        if (!aresetn) begin
            pw <= '0; ph <= '0; rot <= '0;
            swipe_min <= 10'd40; still_max <= 10'd20;
            long_ms <= 16'd800; hold_ms <= 16'd3000;
            gs = GS_IDLE;
            org_rx = 0; org_ry = 0; last_rx = 0; last_ry = 0;
            org_sx = 0; org_sy = 0; ptr_x = 0; ptr_y = 0;
            press_t = '0; home_done = 1'b0;
            expected_q.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_PANEL_W: pw <= cfg_data;
                    REG_PANEL_H: ph <= cfg_data;
                    REG_ROT:     rot <= cfg_data[1:0];
                    REG_SWIPE:   swipe_min <= cfg_data[9:0];
                    REG_STILL:   still_max <= cfg_data[9:0];
                    REG_LONG:    long_ms <= cfg_data;
                    REG_HOLD:    hold_ms <= cfg_data;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_q.push_back(classify_sample(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[41:0];
                if (expected_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result word %h", got);
                end else begin
                    want = expected_q.pop_front();
                    if (got !== want || m_axis_tdata[47:42] !== '0) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("result mismatch: expected %h, got %h",
                                     want, m_axis_tdata);
                    end
                end
            end
        end
        pending_count = expected_q.size();
    end

    initial begin
        mismatch_count = 0;
        pending_count = 0;
    end
endmodule

@@ tb/sv/tb_top.sv @@
module tb_top;
    import tgc_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;
    int          mismatch_count;
    int          pending_count;
    int          src_idle_pct;
    int          snk_stall_pct;
    logic [31:0] clock_ms;

    touch_gesture_classifier u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    tgc_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .mismatch_count(mismatch_count), .pending_count(pending_count)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // random receiver stalls
    always @(posedge aclk) begin
        if (!aresetn) m_axis_tready <= 1'b0;
        else m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // drive a register write, then drop the enable before the task returns
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // wait for all results, then let the block settle before touching registers
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        repeat (2) @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    // tvalid stays high after the accepting edge until the next word or an idle cycle
    task automatic send_sample(input logic down, input logic [15:0] rx,
                               input logic [15:0] ry, input logic [31:0] t);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {7'd0, t, ry, rx, down};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
    endtask

    // one gesture: press, up to four moves, release; times advance by random steps
    task automatic send_gesture(input int x0, input int y0, input int span, input int max_dt);
        int n, x, y;
        n = $urandom_range(4);
        x = x0;
        y = y0;
        send_sample(1'b1, x[15:0], y[15:0], clock_ms);
        for (int k = 0; k < n; k++) begin
            clock_ms += $urandom_range(max_dt);
            x = x0 + $signed($urandom_range(2 * span)) - span;
            y = y0 + $signed($urandom_range(2 * span)) - span;
            send_sample(1'b1, x[15:0], y[15:0], clock_ms);
        end
        clock_ms += $urandom_range(max_dt);
        send_sample(1'b0, 16'($urandom), 16'($urandom), clock_ms);
    endtask

    task automatic random_phase(input int gestures);
        int pick;
        for (int g = 0; g < gestures; g++) begin
            pick = $urandom_range(9);
            if (pick == 0) begin
                send_sample(1'($urandom_range(1)), 16'($urandom), 16'($urandom), $urandom);
            end else if (pick < 3) begin
                // status bar hold, small jitter
                send_gesture($urandom_range(400), $urandom_range(30), 15, 2000);
            end else if (pick < 5) begin
                // back edge candidates
                send_gesture($urandom_range(80, 320), $urandom_range(260, 320), 120, 300);
            end else begin
                send_gesture($urandom_range(500) - 50, $urandom_range(400) - 50,
                             $urandom_range(1) ? 30 : 200, $urandom_range(1) ? 1000 : 100);
            end
            clock_ms += $urandom_range(50);
        end
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        src_idle_pct = 10;
        snk_stall_pct = 71;
        clock_ms = 32'd1000;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: field extremes, every action but up, ties, wrap of time
        send_sample(1'b1, 16'h7FFF, 16'h8000, 32'hFFFF_FFF0);
        send_sample(1'b0, 16'h8000, 16'h7FFF, 32'h0000_0400);
        send_sample(1'b1, 16'd200, 16'd150, 32'd0);
        send_sample(1'b0, 16'd0, 16'd0, 32'd10);
        send_sample(1'b1, 16'd200, 16'd150, 32'd100);
        send_sample(1'b0, 16'd0, 16'd0, 32'd900);
        send_sample(1'b1, 16'd50, 16'd5, 32'd1000);
        send_sample(1'b1, 16'd55, 16'd8, 32'd4000);
        send_sample(1'b1, 16'd55, 16'd8, 32'd9000);
        send_sample(1'b0, 16'd0, 16'd0, 32'd9100);
        send_sample(1'b1, 16'd200, 16'd290, 32'd100);
        send_sample(1'b1, 16'd200, 16'd240, 32'd200);
        send_sample(1'b0, 16'd0, 16'd0, 32'd300);
        send_sample(1'b1, 16'd100, 16'd100, 32'd0);
        send_sample(1'b1, 16'd40, 16'd40, 32'd50);
        send_sample(1'b0, 16'd0, 16'd0, 32'd60);
        send_sample(1'b1, 16'd100, 16'd100, 32'd0);
        send_sample(1'b1, 16'd160, 16'd100, 32'd50);
        send_sample(1'b0, 16'd0, 16'd0, 32'd60);
        send_sample(1'b1, 16'd100, 16'd100, 32'd0);
        send_sample(1'b1, 16'd100, 16'd200, 32'd50);
        send_sample(1'b0, 16'd0, 16'd0, 32'd60);
        send_sample(1'b1, 16'd10, 16'd5, 32'hFFFF_FF00);
        send_sample(1'b1, 16'd10, 16'd5, 32'h7FFF_0000);
        send_sample(1'b0, 16'd0, 16'd0, 32'h8000_0000);
        random_phase(50);
        drain();

        write_reg(REG_PANEL_W, 16'd800);
        write_reg(REG_PANEL_H, 16'd600);
        write_reg(REG_ROT, 16'd1);
        write_reg(REG_SWIPE, 16'd0);
        write_reg(REG_STILL, 16'd1023);
        write_reg(REG_LONG, 16'd0);
        write_reg(REG_HOLD, 16'd0);
        write_reg(3'd7, 16'hFFFF);
        random_phase(50);
        drain();

        src_idle_pct = 71;
        snk_stall_pct = 10;
        write_reg(REG_PANEL_W, 16'hFFFF);
        write_reg(REG_PANEL_H, 16'd1);
        write_reg(REG_ROT, 16'd2);
        write_reg(REG_SWIPE, 16'd1023);
        write_reg(REG_STILL, 16'd0);
        write_reg(REG_LONG, 16'hFFFF);
        write_reg(REG_HOLD, 16'hFFFF);
        random_phase(50);
        drain();

        write_reg(REG_PANEL_W, 16'd0);
        write_reg(REG_PANEL_H, 16'd300);
        write_reg(REG_ROT, 16'd3);
        write_reg(REG_SWIPE, 16'd40);
        write_reg(REG_STILL, 16'd20);
        write_reg(REG_LONG, 16'd800);
        write_reg(REG_HOLD, 16'd3000);
        random_phase(50);
        drain();

        src_idle_pct = 0;
        snk_stall_pct = 0;
        write_reg(REG_PANEL_W, 16'd1);
        write_reg(REG_PANEL_H, 16'd1);
        write_reg(REG_ROT, 16'd0);
        random_phase(50);
        drain();

        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("Mismatches found");
        $finish;
    end
endmodule

@@ filelist.f @@
rtl/tgc_pkg.sv
rtl/tgc_divider.sv
rtl/tgc_mapper.sv
rtl/tgc_fifo.sv
rtl/tgc_classifier.sv
rtl/touch_gesture_classifier.sv
rtl/tgc_checker.sv
tb/sv/tgc_checker.sv
tb/sv/tb_top.sv
